/* src/status_led_pattern_framer_defines.svh */
// Assertion macros shared by the status LED framer RTL.
// Depends on nothing; modules using it must have clk and rst_n in scope.
`ifndef STATUS_LED_PATTERN_FRAMER_DEFINES_SVH
`define STATUS_LED_PATTERN_FRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every edge outside reset
`define SLPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond at one edge implies prop at the next edge
`define SLPF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define SLPF_ASSERT(label, prop, msg)
`define SLPF_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

/* src/slpf_pkg.sv */
// Types and constants for the status LED pattern framer.
// No dependencies.
package slpf_pkg;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_BOOTING    = 3'd1,
    MODE_CONNECTING = 3'd2,
    MODE_LINK_UP    = 3'd3,
    MODE_SESSION_UP = 3'd4,
    MODE_ACTIVE     = 3'd5,
    MODE_ERROR      = 3'd6
  } status_mode_t;

  localparam int unsigned PHASE_MOD   = 20;
  localparam int unsigned PHASE_HALF  = 10;
  localparam int unsigned FRAME_BYTES = 12;

  // byte positions within a frame
  localparam logic [3:0] IDX_HDR   = 4'd4;
  localparam logic [3:0] IDX_BLUE  = 4'd5;
  localparam logic [3:0] IDX_GREEN = 4'd6;
  localparam logic [3:0] IDX_RED   = 4'd7;
  localparam logic [3:0] IDX_LAST  = 4'(FRAME_BYTES - 1);

  localparam logic [7:0] START_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam logic [7:0] HDR_BASE   = 8'hE0;

  localparam logic [7:0] BOOT_STEP    = 8'd25;
  localparam logic [7:0] CONN_BLUE    = 8'd100;
  localparam logic [7:0] LINK_BLUE    = 8'd50;
  localparam logic [7:0] SESSION_GRN  = 8'd50;
  localparam logic [7:0] ACTIVE_LEVEL = 8'd40;
  localparam logic [7:0] ERROR_RED    = 8'd80;

  localparam logic [4:0] BRIGHT_RESET = 5'd15;

  // one queued frame: the four bytes that vary
  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } frame_desc_t;

endpackage

/* src/slpf_if.sv */
// Valid/ready channel interfaces for tick input, frame byte output and config.
// Depends on nothing.
interface slpf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] status_mode;
  modport source (output valid, output status_mode, input ready);
  modport sink   (input valid, input status_mode, output ready);
endinterface

interface slpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_of_frame;
  modport source (output valid, output frame_byte, output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input last_of_frame, output ready);
endinterface

interface slpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] global_brightness;
  modport source (output valid, output global_brightness, input ready);
  modport sink   (input valid, input global_brightness, output ready);
endinterface

/* src/status_led_pattern_framer.sv */
// Status LED pattern framer: one 12-byte single-LED frame per status tick.
// Uses slpf_pkg, slpf_if, slpf_front, slpf_queue and slpf_back.
//
// Usage:
//   in_ch  : one beat per 100 ms tick, carrying status_mode (0..6; 7 yields
//            no frame but still advances the phase).
//   out_ch : twelve beats per frame, frame_byte to be shifted MSB first:
//            four 0x00, header, blue, green, red, four 0xFF; last_of_frame
//            marks the twelfth beat.
//   cfg_ch : writes global_brightness (always ready); write only while idle.
// Output: a tick's descriptor is registered in the queue, and its frame's first
//   byte is valid once that descriptor is at the queue head. One byte per cycle
//   on the byte-wide output port while out_ch.ready is high. The descriptor queue
//   holds QUEUE_DEPTH frames, so ticks keep being taken while a frame is still going out.
// Reset: phase 0, brightness 15, queue empty, nothing on the output.
// Stall: when out_ch.ready is low the current byte holds; once the queue is
//   full, in_ch.ready drops until a frame completes.
module status_led_pattern_framer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  slpf_in_if.sink     in_ch,
  slpf_out_if.source  out_ch,
  slpf_cfg_if.sink    cfg_ch
);

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  slpf_pkg::frame_desc_t q_desc;
  slpf_pkg::frame_desc_t q_head;

  slpf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (q_desc)
  );

  slpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  slpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* src/slpf_front.sv */
// Front end: accepts ticks, tracks the phase, turns mode into a frame descriptor.
// Depends on slpf_pkg, slpf_if and the defines header.
`include "status_led_pattern_framer_defines.svh"

module slpf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  slpf_in_if.sink              in_ch,
  slpf_cfg_if.sink             cfg_ch,
  input  logic                 q_full,
  output logic                 q_push,
  output slpf_pkg::frame_desc_t q_desc
);

  logic [4:0] phase_r, phase_nxt;
  logic [4:0] bright_r, bright_nxt;
  logic [3:0] phase_lo;
  logic [3:0] tri_step;
  logic [7:0] boot_level;
  logic [7:0] lit_hdr;
  logic       has_frame;
  logic       accept;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign lit_hdr      = slpf_pkg::HDR_BASE | {3'b000, bright_r};

  // triangle: rising over the first half, falling over the second
  always_comb begin
    if (phase_r < 5'(slpf_pkg::PHASE_HALF)) begin
      phase_lo = phase_r[3:0];
      tri_step = phase_lo;
    end else begin
      phase_lo = 4'(phase_r - 5'(slpf_pkg::PHASE_HALF));
      tri_step = 4'(slpf_pkg::PHASE_HALF) - phase_lo;
    end
    boot_level = 8'({4'b0000, tri_step} * slpf_pkg::BOOT_STEP);
  end

  always_comb begin
    q_desc    = '{hdr: slpf_pkg::HDR_BASE, blue: 8'd0, green: 8'd0, red: 8'd0};
    has_frame = 1'b1;
    case (slpf_pkg::status_mode_t'(in_ch.status_mode))
      slpf_pkg::MODE_OFF: begin
      end
      slpf_pkg::MODE_BOOTING: begin
        q_desc.hdr  = lit_hdr;
        q_desc.blue = boot_level;
      end
      slpf_pkg::MODE_CONNECTING: begin
        // on for two ticks, off for two
        if (!phase_r[1]) begin
          q_desc.hdr  = lit_hdr;
          q_desc.blue = slpf_pkg::CONN_BLUE;
        end
      end
      slpf_pkg::MODE_LINK_UP: begin
        q_desc.hdr  = lit_hdr;
        q_desc.blue = slpf_pkg::LINK_BLUE;
      end
      slpf_pkg::MODE_SESSION_UP: begin
        q_desc.hdr   = lit_hdr;
        q_desc.green = slpf_pkg::SESSION_GRN;
      end
      slpf_pkg::MODE_ACTIVE: begin
        q_desc.hdr   = lit_hdr;
        q_desc.blue  = slpf_pkg::ACTIVE_LEVEL;
        q_desc.green = slpf_pkg::ACTIVE_LEVEL;
        q_desc.red   = slpf_pkg::ACTIVE_LEVEL;
      end
      slpf_pkg::MODE_ERROR: begin
        q_desc.hdr = lit_hdr;
        q_desc.red = slpf_pkg::ERROR_RED;
      end
      default: has_frame = 1'b0;  // unknown mode: no frame, phase still moves
    endcase
  end

  assign q_push = accept && has_frame;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = (phase_r >= 5'(slpf_pkg::PHASE_MOD - 1)) ? 5'd0 : phase_r + 5'd1;
    end
    bright_nxt = bright_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      bright_nxt = cfg_ch.global_brightness;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 5'd0;
      bright_r <= slpf_pkg::BRIGHT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      bright_r <= bright_nxt;
    end
  end

  `SLPF_ASSERT(a_phase_range, phase_r < 5'(slpf_pkg::PHASE_MOD), "phase out of range")
  `SLPF_ASSERT_NEXT(a_phase_step, accept && phase_r != 5'(slpf_pkg::PHASE_MOD - 1),
    phase_r == $past(phase_r) + 5'd1, "phase did not advance on tick")

endmodule

/* src/slpf_queue.sv */
// Small register FIFO of frame descriptors between front and back ends.
// Depends on slpf_pkg and the defines header.
`include "status_led_pattern_framer_defines.svh"

module slpf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slpf_pkg::frame_desc_t push_desc,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output slpf_pkg::frame_desc_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  slpf_pkg::frame_desc_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  `SLPF_ASSERT(a_no_overflow, !(push && full), "push into full queue")

endmodule

/* src/slpf_back.sv */
// Back end: walks one queued descriptor out as twelve frame byte beats.
// Depends on slpf_pkg, slpf_if and the defines header.
`include "status_led_pattern_framer_defines.svh"

module slpf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  slpf_pkg::frame_desc_t q_head,
  output logic                  q_pop,
  slpf_out_if.source            out_ch
);

  logic [3:0] idx_r, idx_nxt;
  logic       beat;

  assign out_ch.valid         = !q_empty;
  assign out_ch.last_of_frame = (idx_r == slpf_pkg::IDX_LAST);
  assign beat                 = out_ch.valid && out_ch.ready;
  assign q_pop                = beat && (idx_r == slpf_pkg::IDX_LAST);

  always_comb begin
    case (idx_r) inside
      [4'd0:4'd3]:         out_ch.frame_byte = slpf_pkg::START_BYTE;
      slpf_pkg::IDX_HDR:   out_ch.frame_byte = q_head.hdr;
      slpf_pkg::IDX_BLUE:  out_ch.frame_byte = q_head.blue;
      slpf_pkg::IDX_GREEN: out_ch.frame_byte = q_head.green;
      slpf_pkg::IDX_RED:   out_ch.frame_byte = q_head.red;
      default:             out_ch.frame_byte = slpf_pkg::END_BYTE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (beat) begin
      idx_nxt = (idx_r == slpf_pkg::IDX_LAST) ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // a started frame keeps its descriptor until the end byte goes out
  `SLPF_ASSERT(a_frame_held, (idx_r == 4'd0) || !q_empty, "frame lost mid-way")
  `SLPF_ASSERT(a_idx_range, idx_r <= slpf_pkg::IDX_LAST, "byte index out of range")

endmodule

/* tb/slpf_frame_checker.sv */
// Scoreboard for the status LED framer: watches tick, brightness and byte beats,
// predicts each 12-byte frame and compares every byte. Uses slpf_pkg.
`timescale 1ns / 1ps

module slpf_frame_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_valid,
  input  logic              tick_ready,
  input  logic [2:0]        tick_mode,
  input  logic              byte_valid,
  input  logic              byte_ready,
  input  logic [7:0]        byte_data,
  input  logic              byte_last,
  input  logic              bright_valid,
  input  logic              bright_ready,
  input  logic [4:0]        bright_data,
  output int unsigned       mismatches,
  output int unsigned       bytes_outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } led_byte_t;

  led_byte_t   expected_bytes[$];
  logic [4:0]  brightness;
  logic [4:0]  phase;

  // Returns 0 when the mode draws no frame.
  function automatic logic led_pattern(input logic [2:0] mode, input logic [4:0] ph,
                                       input logic [4:0] bright,
                                       output slpf_pkg::frame_desc_t desc);
    int unsigned ramp;
    desc.hdr   = slpf_pkg::HDR_BASE | {3'b000, bright};
    desc.blue  = 8'h00;
    desc.green = 8'h00;
    desc.red   = 8'h00;
    led_pattern = 1'b1;
    case (slpf_pkg::status_mode_t'(mode))
      slpf_pkg::MODE_OFF: begin
        desc.hdr = slpf_pkg::HDR_BASE;
      end
      slpf_pkg::MODE_BOOTING: begin
        // triangle: rises over the first half of the phase cycle, falls over the second
        ramp = (ph < slpf_pkg::PHASE_HALF) ? (ph % slpf_pkg::PHASE_HALF) :
               (slpf_pkg::PHASE_HALF - (ph % slpf_pkg::PHASE_HALF));
        desc.blue = 8'(ramp * slpf_pkg::BOOT_STEP);
      end
      slpf_pkg::MODE_CONNECTING: begin
        if ((ph % 4) < 2) begin
          desc.blue = slpf_pkg::CONN_BLUE;
        end else begin
          desc.hdr = slpf_pkg::HDR_BASE;
        end
      end
      slpf_pkg::MODE_LINK_UP:    desc.blue = slpf_pkg::LINK_BLUE;
      slpf_pkg::MODE_SESSION_UP: desc.green = slpf_pkg::SESSION_GRN;
      slpf_pkg::MODE_ACTIVE: begin
        desc.blue  = slpf_pkg::ACTIVE_LEVEL;
        desc.green = slpf_pkg::ACTIVE_LEVEL;
        desc.red   = slpf_pkg::ACTIVE_LEVEL;
      end
      slpf_pkg::MODE_ERROR:      desc.red = slpf_pkg::ERROR_RED;
      default:                   led_pattern = 1'b0;
    endcase
  endfunction

  function automatic void queue_frame(input slpf_pkg::frame_desc_t desc);
    led_byte_t b;
    for (int i = 0; i < slpf_pkg::FRAME_BYTES; i++) begin
      case (4'(i))
        slpf_pkg::IDX_HDR:   b.data = desc.hdr;
        slpf_pkg::IDX_BLUE:  b.data = desc.blue;
        slpf_pkg::IDX_GREEN: b.data = desc.green;
        slpf_pkg::IDX_RED:   b.data = desc.red;
        default:             b.data = (4'(i) < slpf_pkg::IDX_HDR) ? slpf_pkg::START_BYTE :
                                                                    slpf_pkg::END_BYTE;
      endcase
      b.last = (4'(i) == slpf_pkg::IDX_LAST);
      expected_bytes.push_back(b);
    end
  endfunction

  initial begin
    mismatches        = 0;
    bytes_outstanding = 0;
    brightness        = slpf_pkg::BRIGHT_RESET;
    phase             = '0;
  end

  always @(posedge clk) begin
    led_byte_t             want;
    slpf_pkg::frame_desc_t desc;
    if (!rst_n) begin
      expected_bytes.delete();
      brightness = slpf_pkg::BRIGHT_RESET;
      phase      = '0;
    end else begin
      // byte beats first: a tick accepted at this edge cannot produce one yet
      if (byte_valid && byte_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          $display("%0t: frame_byte expected no beat, got %02h last %b",
                   $time, byte_data, byte_last);
        end else begin
          want = expected_bytes.pop_front();
          if (byte_data !== want.data) begin
            mismatches++;
            $display("%0t: frame_byte expected %02h, got %02h", $time, want.data, byte_data);
          end
          if (byte_last !== want.last) begin
            mismatches++;
            $display("%0t: last_of_frame expected %b, got %b", $time, want.last, byte_last);
          end
        end
      end
      if (bright_valid && bright_ready)
        brightness = bright_data;
      if (tick_valid && tick_ready) begin
        if (led_pattern(tick_mode, phase, brightness, desc))
          queue_frame(desc);
        phase = (phase + 1 >= slpf_pkg::PHASE_MOD) ? 5'd0 : phase + 5'd1;
      end
    end
    bytes_outstanding <= expected_bytes.size();
  end

endmodule

/* tb/tb_status_led_pattern_framer.sv */
// Top of the status LED framer testbench: clock, reset, tick and brightness
// stimulus, byte-side backpressure and the verdict. Uses slpf_pkg, slpf_if, slpf_frame_checker.
`timescale 1ns / 1ps

module tb_status_led_pattern_framer;

  localparam logic [2:0]  MODE_UNUSED   = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IDLE_PCT      = 34;
  localparam time         RUN_LIMIT     = 5_000_000;

  logic clk;
  logic rst_n;
  logic tx_idle_en;
  logic rx_stall_en;
  logic hold_req;
  int unsigned mismatches;
  int unsigned bytes_outstanding;

  slpf_in_if  in_ch ();
  slpf_out_if out_ch ();
  slpf_cfg_if cfg_ch ();

  status_led_pattern_framer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  slpf_frame_checker frame_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .tick_valid        (in_ch.valid),
    .tick_ready        (in_ch.ready),
    .tick_mode         (in_ch.status_mode),
    .byte_valid        (out_ch.valid),
    .byte_ready        (out_ch.ready),
    .byte_data         (out_ch.frame_byte),
    .byte_last         (out_ch.last_of_frame),
    .bright_valid      (cfg_ch.valid),
    .bright_ready      (cfg_ch.ready),
    .bright_data       (cfg_ch.global_brightness),
    .mismatches        (mismatches),
    .bytes_outstanding (bytes_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("[status_led_pattern_framer] ERROR");
    $finish;
  end

  // byte sink: random stalls, or a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= rx_stall_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [2:0] mode);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid       <= 1'b0;
      in_ch.status_mode <= 3'($urandom);
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.status_mode <= mode;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // status tends to persist for a while, so booting and connecting sweep the phases
  task automatic send_status_run(input int unsigned count);
    logic [2:0] mode;
    mode = 3'($urandom);
    repeat (count) begin
      if ($urandom_range(4) == 0)
        mode = 3'($urandom);
      send_tick(mode);
    end
  endtask

  task automatic wait_frames_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [4:0] level);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.global_brightness <= level;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n                    = 1'b0;
    tx_idle_en               = 1'b1;
    rx_stall_en              = 1'b1;
    hold_req                 = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.status_mode        = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.global_brightness = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode, booting at phases 1 to 19, reset brightness
    send_tick(slpf_pkg::MODE_OFF);
    repeat (19) send_tick(slpf_pkg::MODE_BOOTING);
    send_tick(slpf_pkg::MODE_CONNECTING);
    send_tick(slpf_pkg::MODE_LINK_UP);
    send_tick(slpf_pkg::MODE_SESSION_UP);
    send_tick(slpf_pkg::MODE_ACTIVE);
    send_tick(slpf_pkg::MODE_ERROR);
    send_tick(MODE_UNUSED);
    wait_frames_done();

    // zero brightness: lit frames keep their colour with a bare header
    write_brightness(5'd0);
    send_status_run(100);
    wait_frames_done();

    // full brightness, byte side held off so the frame queue fills and ticks back up
    write_brightness(5'd31);
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    send_status_run(40);
    wait_frames_done();

    // long stretch with no idling on either side
    write_brightness(5'($urandom_range(30, 1)));
    rx_stall_en = 1'b0;
    send_status_run(120);
    wait_frames_done();

    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    write_brightness(5'($urandom));
    send_status_run(120);
    wait_frames_done();

    write_brightness(slpf_pkg::BRIGHT_RESET);
    send_status_run(100);
    wait_frames_done();

    if (mismatches == 0) begin
      $display("[status_led_pattern_framer] OK");
    end else begin
      $display("[status_led_pattern_framer] ERROR");
    end
    $finish;
  end

endmodule
